FILE: rtl/core/signal_plausibility_monitor_macros.svh
// ----------------------------------------------------------------------------
// Signal plausibility monitor: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet while in reset.
// ----------------------------------------------------------------------------
`ifndef SIGNAL_PLAUSIBILITY_MONITOR_MACROS_SVH
`define SIGNAL_PLAUSIBILITY_MONITOR_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define SPM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("signal plausibility monitor: assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define SPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("signal plausibility monitor: assertion failed");
`else
`define SPM_ASSERT_SAME(label, ante, cons)
`define SPM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/core/spm_pkg.sv
// ----------------------------------------------------------------------------
// Signal plausibility monitor package
// Types, register map and constants shared by the monitor's modules.
// ----------------------------------------------------------------------------
package spm_pkg;

    // Width of sample values, timestamps and report fields.
    localparam int DATA_BITS = 32;

    // Configuration port address width and register map.
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_IDX_BITS  = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_LOW    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_HIGH   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPIKE_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FREEZE_TIME  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FREEZE_COUNT = 3'd4;

    // Report queue between front and back; the depth is a power of two.
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Report kinds.
    typedef enum logic [1:0] {
        KIND_RANGE  = 2'd0,
        KIND_SPIKE  = 2'd1,
        KIND_FROZEN = 2'd2
    } kind_t;

    // Live configuration seen by the front.
    typedef struct packed {
        logic signed [DATA_BITS-1:0] range_low;
        logic signed [DATA_BITS-1:0] range_high;
        logic [DATA_BITS-1:0]        spike_limit;
        logic [DATA_BITS-1:0]        freeze_time_limit;
        logic [15:0]                 freeze_count_limit;
    } cfg_t;

    // Report flags of one sample, one bit per kind.
    typedef struct packed {
        logic frozen;
        logic spike;
        logic range;
    } flags_t;

    // One queued sample with everything its reports need.
    typedef struct packed {
        flags_t                      flags;
        logic [DATA_BITS-1:0]        stamp;
        logic signed [DATA_BITS-1:0] sample;
        logic [DATA_BITS-1:0]        step;
        logic [DATA_BITS-1:0]        run_start;
        logic [DATA_BITS-1:0]        run_count;
    } entry_t;

    // Queue status towards front and back.
    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

endpackage

FILE: rtl/core/spm_if.sv
// ----------------------------------------------------------------------------
// Signal plausibility monitor channels
// Valid/ready channels for incoming samples and outgoing reports.
// ----------------------------------------------------------------------------

// Sample channel: one word is one timestamped sample.
interface spm_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;
    logic [31:0]        stamp;
    logic               series_start;

    modport source (output valid, sample, stamp, series_start, input ready);
    modport sink   (input valid, sample, stamp, series_start, output ready);
endinterface

// Report channel: one word is one report.
interface spm_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [31:0]        report_time;
    logic signed [31:0] report_value;
    logic [31:0]        detail;
    logic               last;

    modport source (output valid, kind, report_time, report_value, detail, last,
                    input ready);
    modport sink   (input valid, kind, report_time, report_value, detail, last,
                    output ready);
endinterface

FILE: rtl/core/spm_cfg_regs.sv
// ----------------------------------------------------------------------------
// Signal plausibility monitor configuration registers
// APB-style register bank holding the range, spike and freeze limits.
// ----------------------------------------------------------------------------
module spm_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [spm_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output spm_pkg::cfg_t                      cfg
);
    import spm_pkg::*;

    cfg_t                    cfg_reg;
    cfg_t                    cfg_next;
    logic [CFG_IDX_BITS-1:0] idx;
    logic                    wr_en;

    assign idx    = paddr[CFG_ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_RANGE_LOW:    cfg_next.range_low          = signed'(pwdata);
                REG_RANGE_HIGH:   cfg_next.range_high         = signed'(pwdata);
                REG_SPIKE_LIMIT:  cfg_next.spike_limit        = pwdata;
                REG_FREEZE_TIME:  cfg_next.freeze_time_limit  = pwdata;
                REG_FREEZE_COUNT: cfg_next.freeze_count_limit = pwdata[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (idx)
            REG_RANGE_LOW:    prdata = cfg_reg.range_low;
            REG_RANGE_HIGH:   prdata = cfg_reg.range_high;
            REG_SPIKE_LIMIT:  prdata = cfg_reg.spike_limit;
            REG_FREEZE_TIME:  prdata = cfg_reg.freeze_time_limit;
            REG_FREEZE_COUNT: prdata = {16'd0, cfg_reg.freeze_count_limit};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/spm_front.sv
// ----------------------------------------------------------------------------
// Signal plausibility monitor front end
// Accepts samples, runs the range, spike and frozen-run checks against the
// stored history and pushes samples that raise reports into the queue.
// ----------------------------------------------------------------------------
module spm_front #(
    parameter int RUN_COUNT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    spm_in_if.sink             samples,
    input  spm_pkg::cfg_t      cfg,
    input  spm_pkg::q_status_t q_status,
    output logic               push,
    output spm_pkg::entry_t    push_entry
);
    import spm_pkg::*;

    localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX = '1;
    localparam logic [RUN_COUNT_BITS-1:0] RUN_ONE = RUN_COUNT_BITS'(1);
    localparam logic [RUN_COUNT_BITS-1:0] RUN_TWO = RUN_COUNT_BITS'(2);

    // History registers.
    logic                        have_prev_reg,    have_prev_next;
    logic signed [DATA_BITS-1:0] prev_sample_reg,  prev_sample_next;
    logic [DATA_BITS-1:0]        prev_time_reg,    prev_time_next;
    logic signed [DATA_BITS-1:0] run_value_reg,    run_value_next;
    logic [DATA_BITS-1:0]        run_start_reg,    run_start_next;
    logic [RUN_COUNT_BITS-1:0]   run_length_reg,   run_length_next;
    logic                        run_reported_reg, run_reported_next;

    logic                        accept;
    logic                        hp;
    logic [RUN_COUNT_BITS-1:0]   rl;
    logic                        rr;
    logic signed [DATA_BITS:0]   diff;
    logic [DATA_BITS:0]          step_wide;
    logic [DATA_BITS-1:0]        step;
    logic                        in_run;
    logic [RUN_COUNT_BITS-1:0]   rl_inc;
    logic [DATA_BITS-1:0]        dur;
    logic [DATA_BITS-1:0]        gap;
    logic                        time_hit;
    logic                        count_hit;
    flags_t                      flags;

    assign samples.ready = !q_status.full;
    assign accept        = samples.valid && samples.ready;

    // A series start wipes the history before this sample is judged.
    assign hp = have_prev_reg && !samples.series_start;
    assign rl = samples.series_start ? '0 : run_length_reg;
    assign rr = run_reported_reg && !samples.series_start;

    // Exact step magnitude in one extra bit, then back to 32 bits.
    assign diff      = {samples.sample[DATA_BITS-1], samples.sample}
                     - {prev_sample_reg[DATA_BITS-1], prev_sample_reg};
    assign step_wide = diff[DATA_BITS] ? ((DATA_BITS+1)'(0) - diff) : diff;
    assign step      = step_wide[DATA_BITS-1:0];

    // Run of equal values and its freeze conditions.
    assign in_run    = (rl != '0) && (samples.sample == run_value_reg);
    assign rl_inc    = (rl == RUN_MAX) ? rl : rl + RUN_ONE;
    assign dur       = samples.stamp - run_start_reg;
    assign gap       = samples.stamp - prev_time_reg;
    assign time_hit  = (cfg.freeze_time_limit != '0) && (dur >= cfg.freeze_time_limit)
                    && ((rl_inc == RUN_TWO)
                        || ({gap, 1'b0} < {1'b0, cfg.freeze_time_limit}));
    assign count_hit = (cfg.freeze_count_limit != '0)
                    && (32'(rl_inc) >= 32'(cfg.freeze_count_limit));

    // Report flags.
    always_comb
    begin
        flags.range  = (samples.sample < cfg.range_low)
                    || (samples.sample > cfg.range_high);
        flags.spike  = hp && (cfg.spike_limit != '0) && (step > cfg.spike_limit);
        flags.frozen = in_run && (time_hit || count_hit) && !rr;
    end

    assign push = accept && (flags != '0);

    // Queue entry; the frozen value equals the sample itself.
    always_comb
    begin
        push_entry.flags     = flags;
        push_entry.stamp     = samples.stamp;
        push_entry.sample    = samples.sample;
        push_entry.step      = step;
        push_entry.run_start = run_start_reg;
        push_entry.run_count = 32'(rl_inc);
    end

    // History update on every accepted sample.
    always_comb
    begin
        have_prev_next    = have_prev_reg;
        prev_sample_next  = prev_sample_reg;
        prev_time_next    = prev_time_reg;
        run_value_next    = run_value_reg;
        run_start_next    = run_start_reg;
        run_length_next   = run_length_reg;
        run_reported_next = run_reported_reg;
        if (accept)
        begin
            have_prev_next   = 1'b1;
            prev_sample_next = samples.sample;
            prev_time_next   = samples.stamp;
            if (in_run)
            begin
                run_length_next   = rl_inc;
                run_reported_next = rr || flags.frozen;
            end
            else
            begin
                run_value_next    = samples.sample;
                run_start_next    = samples.stamp;
                run_length_next   = RUN_ONE;
                run_reported_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg    <= 1'b0;
            prev_sample_reg  <= '0;
            prev_time_reg    <= '0;
            run_value_reg    <= '0;
            run_start_reg    <= '0;
            run_length_reg   <= '0;
            run_reported_reg <= 1'b0;
        end
        else
        begin
            have_prev_reg    <= have_prev_next;
            prev_sample_reg  <= prev_sample_next;
            prev_time_reg    <= prev_time_next;
            run_value_reg    <= run_value_next;
            run_start_reg    <= run_start_next;
            run_length_reg   <= run_length_next;
            run_reported_reg <= run_reported_next;
        end
    end

endmodule

FILE: rtl/core/spm_queue.sv
// ----------------------------------------------------------------------------
// Signal plausibility monitor report queue
// Short first-in first-out store of samples that owe reports.
// ----------------------------------------------------------------------------
`include "signal_plausibility_monitor_macros.svh"

module spm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  spm_pkg::entry_t    push_entry,
    input  logic               pop,
    output spm_pkg::entry_t    head,
    output spm_pkg::q_status_t q_status
);
    import spm_pkg::*;

    entry_t                    entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg,  count_next;

    assign head               = entry_reg[rd_ptr_reg];
    assign q_status.not_empty = (count_reg != '0);
    assign q_status.full      = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `SPM_ASSERT_SAME(a_no_overflow, push, !q_status.full)
    `SPM_ASSERT_SAME(a_no_underflow, pop, q_status.not_empty)
    `SPM_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
    `SPM_ASSERT_SAME(a_ptr_gap, 1'b1,
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_PTR_BITS-1:0])

endmodule

FILE: rtl/core/spm_back.sv
// ----------------------------------------------------------------------------
// Signal plausibility monitor back end
// Unpacks each queued sample into its reports, one word per cycle while the
// report port takes them, through an output register.
// ----------------------------------------------------------------------------
`include "signal_plausibility_monitor_macros.svh"

module spm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  spm_pkg::entry_t    head,
    input  spm_pkg::q_status_t q_status,
    output logic               pop,
    spm_out_if.source          reports
);
    import spm_pkg::*;

    flags_t                      done_reg,   done_next;
    logic                        valid_reg,  valid_next;
    kind_t                       kind_reg,   kind_next;
    logic [DATA_BITS-1:0]        time_reg,   time_next;
    logic signed [DATA_BITS-1:0] value_reg,  value_next;
    logic [DATA_BITS-1:0]        detail_reg, detail_next;
    logic                        last_reg,   last_next;

    flags_t remaining;
    flags_t pick;
    logic   load;

    assign remaining = head.flags & ~done_reg;

    // Lowest pending kind goes first.
    always_comb
    begin
        pick = '0;
        if (remaining.range)
        begin
            pick.range = 1'b1;
        end
        else if (remaining.spike)
        begin
            pick.spike = 1'b1;
        end
        else
        begin
            pick.frozen = 1'b1;
        end
    end

    assign load = q_status.not_empty && (!valid_reg || reports.ready);
    assign pop  = load && ((remaining & ~pick) == '0);

    // Report payload and progress through the head entry.
    always_comb
    begin
        valid_next  = valid_reg && !reports.ready;
        kind_next   = kind_reg;
        time_next   = time_reg;
        value_next  = value_reg;
        detail_next = detail_reg;
        last_next   = last_reg;
        done_next   = done_reg;
        if (load)
        begin
            valid_next = 1'b1;
            last_next  = pop;
            done_next  = pop ? flags_t'('0) : (done_reg | pick);
            value_next = head.sample;
            if (pick.range)
            begin
                kind_next   = KIND_RANGE;
                time_next   = head.stamp;
                detail_next = '0;
            end
            else if (pick.spike)
            begin
                kind_next   = KIND_SPIKE;
                time_next   = head.stamp;
                detail_next = head.step;
            end
            else
            begin
                kind_next   = KIND_FROZEN;
                time_next   = head.run_start;
                detail_next = head.run_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        time_reg   <= time_next;
        value_reg  <= value_next;
        detail_reg <= detail_next;
        last_reg   <= last_next;
    end

    assign reports.valid        = valid_reg;
    assign reports.kind         = kind_reg;
    assign reports.report_time  = time_reg;
    assign reports.report_value = value_reg;
    assign reports.detail       = detail_reg;
    assign reports.last         = last_reg;

    `SPM_ASSERT_SAME(a_frozen_is_last, valid_reg && (kind_reg == KIND_FROZEN), last_reg)
    `SPM_ASSERT_SAME(a_head_has_work, q_status.not_empty, remaining != '0)
    `SPM_ASSERT_NEXT(a_pop_clears_done, pop, done_reg == '0)

endmodule

FILE: rtl/core/signal_plausibility_monitor.sv
// ----------------------------------------------------------------------------
// Signal plausibility monitor
// Range, spike and frozen-value checks on one stream of Q16.16 samples.
// ----------------------------------------------------------------------------
// The monitor takes one sample word per clock cycle and judges it in the
// cycle it is accepted, against the previous sample and the current run of
// equal values. A sample can raise up to three reports (range, spike, frozen,
// in that order); those samples go into a four-entry queue and the back end
// sends one report word per cycle while the report port takes them. Each
// report passes through a queue entry and an output register. Sample
// ready drops only while that queue is full, which happens when reports are
// not taken or arrive faster than one a cycle. The user must set the limits
// over the APB port while the monitor is idle; the block does not enforce it.
module signal_plausibility_monitor #(
    parameter int RUN_COUNT_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [spm_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    spm_in_if.sink                             samples,
    spm_out_if.source                          reports
);
    import spm_pkg::*;

    cfg_t      cfg;
    q_status_t q_status;
    logic      push;
    entry_t    push_entry;
    logic      pop;
    entry_t    head;

    spm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spm_front #(
        .RUN_COUNT_BITS (RUN_COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .cfg        (cfg),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    spm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    spm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .reports  (reports)
    );

endmodule

FILE: tb/sv/signal_plausibility_monitor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signal plausibility monitor checker
// Follows limit writes on the APB port and sample words on the input channel.
// It predicts the range, spike and frozen reports of each sample and compares
// every report word taken from the output channel, in order, field by field.
// ----------------------------------------------------------------------------
module signal_plausibility_monitor_checker
    import spm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    input  logic                     pready,
    spm_in_if                        samples,
    spm_out_if                       reports,
    output int                       mismatches,
    output int                       outstanding
);

    localparam int RUN_BITS   = 16;

    typedef struct packed {
        kind_t                       kind;
        logic [DATA_BITS-1:0]        rtime;
        logic signed [DATA_BITS-1:0] value;
        logic [DATA_BITS-1:0]        detail;
        logic                        last;
    } report_t;

    // Limits as last written over the APB port.
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [31:0]        spike_limit;
    logic [31:0]        freeze_ticks;
    logic [15:0]        count_limit;

    // History of the stream: previous sample and the current run of equal values.
    logic               have_prev;
    logic signed [31:0] prev_sample;
    logic [31:0]        prev_time;
    logic signed [31:0] run_value;
    logic [31:0]        run_start;
    logic [RUN_BITS-1:0] run_length;
    logic               run_reported;

    report_t pending_reports[$];

    // Prints one line per mismatch and counts every one.
    task automatic flag_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic store_limit(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
        case (idx)
            REG_RANGE_LOW:    range_low    = data;
            REG_RANGE_HIGH:   range_high   = data;
            REG_SPIKE_LIMIT:  spike_limit  = data;
            REG_FREEZE_TIME:  freeze_ticks = data;
            REG_FREEZE_COUNT: count_limit  = data[15:0];
            default: ;
        endcase
    endtask

    // Works out the reports of one accepted sample and updates the history.
    function automatic void judge_sample(input logic signed [31:0] value,
                                         input logic [31:0] stamp, input logic fresh);
        report_t found [3];
        int      n;
        longint  step;
        logic [31:0] dur;
        logic [31:0] gap;
        logic    frozen;
        n = 0;
        frozen = 1'b0;
        if (fresh)
        begin
            have_prev    = 1'b0;
            run_length   = '0;
            run_reported = 1'b0;
        end

        if (value < range_low || value > range_high)
        begin
            found[n] = '{KIND_RANGE, stamp, value, 32'd0, 1'b0};
            n++;
        end

        // Step size is taken exactly, without wrap.
        step = longint'(value) - longint'(prev_sample);
        if (step < 0)
            step = -step;
        if (have_prev && spike_limit != 0 && step > longint'(spike_limit))
        begin
            found[n] = '{KIND_SPIKE, stamp, value, step[31:0], 1'b0};
            n++;
        end

        if (run_length != 0 && value == run_value)
        begin
            if (run_length != '1)
                run_length++;
            dur = stamp - run_start;
            gap = stamp - prev_time;
            if (freeze_ticks != 0 && dur >= freeze_ticks &&
                (run_length == 2 || {gap, 1'b0} < {1'b0, freeze_ticks}))
                frozen = 1'b1;
            if (count_limit != 0 && run_length >= count_limit)
                frozen = 1'b1;
            if (frozen && !run_reported)
            begin
                run_reported = 1'b1;
                found[n] = '{KIND_FROZEN, run_start, run_value, 32'(run_length), 1'b0};
                n++;
            end
        end
        else
        begin
            run_value    = value;
            run_start    = stamp;
            run_length   = 1;
            run_reported = 1'b0;
        end

        have_prev   = 1'b1;
        prev_sample = value;
        prev_time   = stamp;

        if (n > 0)
            found[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_reports.insert(pending_reports.size(), found[i]);
    endfunction

    // Compares one report word with the oldest expected report.
    task automatic check_report();
        report_t want;
        if (pending_reports.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected report kind %0d time %h value %h detail %h",
                                    reports.kind, reports.report_time, reports.report_value,
                                    reports.detail));
        end
        else
        begin
            want = pending_reports.pop_front();
            if (reports.kind !== want.kind || reports.report_time !== want.rtime ||
                reports.report_value !== want.value || reports.detail !== want.detail ||
                reports.last !== want.last)
                flag_mismatch($sformatf(
                    "got kind %0d time %h value %h detail %h last %b, want %0d %h %h %h %b",
                    reports.kind, reports.report_time, reports.report_value,
                    reports.detail, reports.last, want.kind, want.rtime, want.value,
                    want.detail, want.last));
        end
    endtask

    // All channels are sampled at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low    = '0;
            range_high   = '0;
            spike_limit  = '0;
            freeze_ticks = '0;
            count_limit  = '0;
            have_prev    = 1'b0;
            prev_sample  = '0;
            prev_time    = '0;
            run_value    = '0;
            run_start    = '0;
            run_length   = '0;
            run_reported = 1'b0;
            mismatches   = 0;
            pending_reports.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                store_limit(paddr[CFG_ADDR_BITS-1:2], pwdata);
            if (reports.valid && reports.ready)
                check_report();
            if (samples.valid && samples.ready)
                judge_sample(samples.sample, samples.stamp, samples.series_start);
        end
        outstanding = pending_reports.size();
    end

endmodule

FILE: tb/sv/signal_plausibility_monitor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signal plausibility monitor testbench
// Drives sample words and limit writes into the monitor, with random gaps on
// the sample side and random stalls on the report side, while the checker
// predicts and compares every report. Directed samples cover the field
// extremes and the boundary cases; random streams of runs and steps follow
// under several limit settings.
// ----------------------------------------------------------------------------
module signal_plausibility_monitor_tb;
    import spm_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 5;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int Q_ONE          = 65536;
    localparam int PHASE_ITEMS    = 62;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 3'd7;
    localparam logic [31:0] VALUE_MIN = 32'h8000_0000;
    localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    int mismatches;
    int outstanding;
    int idle_cycles;
    int sender_idle_pct;
    int sink_stall_pct;

    logic signed [31:0] cur_value;
    logic [31:0]        cur_stamp;

    spm_in_if  sample_ch ();
    spm_out_if report_ch ();

    signal_plausibility_monitor u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (sample_ch),
        .reports (report_ch)
    );

    signal_plausibility_monitor_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .samples     (sample_ch),
        .reports     (report_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // Report side: ready drops at random according to the current stall rate.
    always @(negedge clk)
    begin
        report_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Ends the run when nothing has moved for too long.
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (report_ch.valid && report_ch.ready) || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // One register write: setup cycle, access cycle, then an idle cycle.
    task automatic apb_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_limits(input logic [31:0] lo, input logic [31:0] hi,
                               input logic [31:0] spike, input logic [31:0] ticks,
                               input logic [15:0] count);
        apb_write(REG_RANGE_LOW, lo);
        apb_write(REG_RANGE_HIGH, hi);
        apb_write(REG_SPIKE_LIMIT, spike);
        apb_write(REG_FREEZE_TIME, ticks);
        apb_write(REG_FREEZE_COUNT, {16'd0, count});
    endtask

    // Sends one sample word, with random idle cycles in front of it.
    task automatic send_sample(input logic signed [31:0] value, input logic [31:0] stamp,
                               input logic fresh);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.sample       <= value;
        sample_ch.stamp        <= stamp;
        sample_ch.series_start <= fresh;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops sending and waits until every expected report has come out.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [31:0] clamp_q(input longint v);
        if (v > longint'(signed'(VALUE_MAX)))
            return VALUE_MAX;
        if (v < longint'(signed'(VALUE_MIN)))
            return VALUE_MIN;
        return v[31:0];
    endfunction

    // Random stream built mostly from runs of equal values and steps near the
    // spike limit, with new series, wide jumps and extreme values mixed in.
    task automatic stream_random_samples(input int count, input int unsigned step_scale,
                                         input int unsigned window,
                                         input int unsigned tick_scale);
        int unsigned pick;
        logic        fresh;
        longint      next;
        repeat (count)
        begin
            pick  = $urandom_range(99);
            fresh = 1'b0;
            if (pick < 6)
            begin
                fresh     = 1'b1;
                cur_value = clamp_q(longint'($urandom_range(2 * window)) - window);
            end
            else if (pick < 46)
            begin
                // Repeat the current value to grow the run.
            end
            else if (pick < 76)
            begin
                next = longint'($urandom_range(step_scale));
                if ($urandom_range(1) != 0)
                    next = -next;
                cur_value = clamp_q(longint'(cur_value) + next);
            end
            else if (pick < 90)
                cur_value = clamp_q(longint'($urandom_range(2 * window)) - window);
            else if (pick < 95)
                cur_value = $urandom;
            else
            begin
                case ($urandom_range(3))
                    0: cur_value = VALUE_MIN;
                    1: cur_value = VALUE_MAX;
                    2: cur_value = 32'd0;
                    default: cur_value = 32'hFFFF_FFFF;
                endcase
            end
            if ($urandom_range(99) < 92)
                cur_stamp = cur_stamp + $urandom_range(tick_scale);
            else
                cur_stamp = cur_stamp + $urandom;
            send_sample(cur_value, cur_stamp, fresh);
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        idle_cycles            = 0;
        sender_idle_pct        = 0;
        sink_stall_pct         = 0;
        cur_value              = '0;
        cur_stamp              = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.sample       = '0;
        sample_ch.stamp        = '0;
        sample_ch.series_start = 1'b0;
        report_ch.ready        = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Limits at their reset values: only zero is in range.
        send_sample(5 * Q_ONE, 10, 1'b1);
        send_sample(0, 20, 1'b0);
        send_sample(0, 30, 1'b0);
        settle();

        // Directed samples against a range of +-10.0, spike 5.0, 100 ticks, 4 samples.
        load_limits(-10 * Q_ONE, 10 * Q_ONE, 5 * Q_ONE, 100, 16'd4);
        send_sample(0, 1000, 1'b1);
        send_sample(VALUE_MAX, 1010, 1'b0);
        send_sample(VALUE_MIN, 1020, 1'b0);
        send_sample(VALUE_MIN, 1030, 1'b0);
        send_sample(VALUE_MIN, 1040, 1'b0);
        // Fourth equal sample reaches the count limit.
        send_sample(VALUE_MIN, 1050, 1'b0);
        send_sample(VALUE_MIN, 1060, 1'b0);
        // Both range edges are allowed; a step of exactly the limit is no spike.
        send_sample(10 * Q_ONE, 1070, 1'b0);
        send_sample(-10 * Q_ONE, 1080, 1'b0);
        send_sample(-5 * Q_ONE, 1090, 1'b0);
        send_sample(1, 1100, 1'b0);
        send_sample(10 * Q_ONE + 1, 1110, 1'b0);
        // A new series forgets the previous sample; the timestamp then wraps.
        send_sample(-9 * Q_ONE, 32'hFFFF_FF00, 1'b1);
        send_sample(-9 * Q_ONE, 32'h0000_0010, 1'b0);
        // Duration reached with a short gap.
        send_sample(2 * Q_ONE, 5000, 1'b1);
        send_sample(2 * Q_ONE, 5090, 1'b0);
        send_sample(2 * Q_ONE, 5110, 1'b0);
        // Duration reached with a long gap: reported only at the next, closer sample.
        send_sample(3 * Q_ONE, 6000, 1'b1);
        send_sample(3 * Q_ONE, 6060, 1'b0);
        send_sample(3 * Q_ONE, 6120, 1'b0);
        send_sample(3 * Q_ONE, 6130, 1'b0);
        send_sample(3 * Q_ONE, 6130, 1'b0);
        send_sample(-11 * Q_ONE, 6140, 1'b0);
        settle();

        // Random phase with no idling on either side.
        load_limits(-8 * Q_ONE, 8 * Q_ONE, 2 * Q_ONE, 60, 16'd5);
        stream_random_samples(PHASE_ITEMS, 3 * Q_ONE, 10 * Q_ONE, 25);
        settle();

        // Sender mostly idle; full range, spike check and duration check off.
        sender_idle_pct = 86;
        load_limits(VALUE_MIN, VALUE_MAX, 32'd0, 32'd0, 16'd3);
        apb_write(REG_UNMAPPED, 32'hDEAD_BEEF);
        stream_random_samples(PHASE_ITEMS, 4 * Q_ONE, 4 * Q_ONE, 25);
        settle();

        // Receiver mostly stalling; inverted range, largest spike limit.
        sender_idle_pct = 0;
        sink_stall_pct  = 86;
        load_limits(4 * Q_ONE, -4 * Q_ONE, 32'hFFFF_FFFF, 50, 16'd0);
        stream_random_samples(PHASE_ITEMS, 2 * Q_ONE, 6 * Q_ONE, 30);
        settle();

        // Both sides idling; smallest limits and the largest count limit.
        sender_idle_pct = 37;
        sink_stall_pct  = 37;
        load_limits(-2 * Q_ONE, 3 * Q_ONE, 32'd1, 32'd1, 16'hFFFF);
        stream_random_samples(PHASE_ITEMS, 4, 4 * Q_ONE, 3);
        settle();

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
